// ----- design/lk3_pkg.sv -----
// Shared types, constants and mixing functions for the byte hash unit.
`default_nettype none

package lk3_pkg;

  // Seed base that is added to the stated message length.
  localparam logic [31:0] SEED_BASE = 32'hdeadbeef;

  // Default depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One classified word, as the front hands it to the back.
  typedef struct packed {
    logic [31:0] data;       // masked message bytes
    logic        has_bytes;  // word carries at least one byte
    logic        first;      // word opens a message
    logic        last;       // word closes a message
    logic [31:0] seed;       // seed for a, b and c when first is set
  } item_t;

  // The three accumulators.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } abc_t;

  // Rotate left by a constant amount between 1 and 31.
  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
    return (x << k) | (x >> (32 - k));
  endfunction

  // Two rows of the block mix; step 0..2 covers all six rows.
  function automatic abc_t block_pair(input abc_t v, input logic [1:0] step);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    abc_t r;
    a = v.a;
    b = v.b;
    c = v.c;
    case (step)
      2'd0: begin
        a = a - c; a = a ^ rotl(c, 4);  c = c + b;
        b = b - a; b = b ^ rotl(a, 6);  a = a + c;
      end
      2'd1: begin
        c = c - b; c = c ^ rotl(b, 8);  b = b + a;
        a = a - c; a = a ^ rotl(c, 16); c = c + b;
      end
      default: begin
        b = b - a; b = b ^ rotl(a, 19); a = a + c;
        c = c - b; c = c ^ rotl(b, 4);  b = b + a;
      end
    endcase
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

  // Two rows of the final mix per step; step 3 holds the seventh row alone.
  function automatic abc_t final_pair(input abc_t v, input logic [1:0] step);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    abc_t r;
    a = v.a;
    b = v.b;
    c = v.c;
    case (step)
      2'd0: begin
        c = c ^ b; c = c - rotl(b, 14);
        a = a ^ c; a = a - rotl(c, 11);
      end
      2'd1: begin
        b = b ^ a; b = b - rotl(a, 25);
        c = c ^ b; c = c - rotl(b, 16);
      end
      2'd2: begin
        a = a ^ c; a = a - rotl(c, 4);
        b = b ^ a; b = b - rotl(a, 14);
      end
      default: begin
        c = c ^ b; c = c - rotl(b, 24);
      end
    endcase
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/lookup3_byte_hash_unit.sv -----
// Top level of the streaming 32-bit byte hash unit.
//
// Input channel: one 32-bit little-endian message word per transfer
// (in_valid / in_stall), with its byte count, first and last marks, and the
// message length on the first word. Output channel: one 32-bit hash per
// message (out_valid / out_stall), presented in a register.
// Words pass through a short queue to the back end, which takes one word per
// cycle unless it is mixing or waiting on a stalled result. Every third word
// that carries bytes after a full 12-byte block first runs the block mix (two
// mix rows per cycle), and no word is taken while it runs. The last word adds
// the final mix, after the block mix when that word has to mix a held block,
// and its hash is then loaded into the result register.
// An empty message returns the seed in the cycle after its last word is taken.
// When the receiver stalls, the result register holds its value and the
// queue keeps taking words until it is full; in_stall rises only then.
// Reset clears the queue, the accumulators and the result register valid.
`default_nettype none

module lookup3_byte_hash_unit #(
  parameter int QUEUE_DEPTH = lk3_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        first_word,
  input  wire logic        last_word,
  input  wire logic [31:0] total_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      hash_value
);
  import lk3_pkg::*;

  logic  q_full;
  logic  q_push;
  item_t q_in;
  logic  q_pop;
  logic  q_valid;
  item_t q_head;

  lk3_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .first_word   (first_word),
    .last_word    (last_word),
    .total_length (total_length),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in)
  );

  lk3_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_item (q_head)
  );

  lk3_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

endmodule

`default_nettype wire

// ----- design/lk3_front.sv -----
// Front part: accepts input words, masks unused bytes and computes the seed.
`default_nettype none

module lk3_front (
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [31:0]   data_word,
  input  wire logic [2:0]    byte_count,
  input  wire logic          first_word,
  input  wire logic          last_word,
  input  wire logic [31:0]   total_length,
  input  wire logic          q_full,
  output logic               q_push,
  output lk3_pkg::item_t     q_item
);
  import lk3_pkg::*;

  logic [31:0] byte_mask;

  // Counts above four behave as four; bytes above the count read as zero.
  always_comb begin
    case (byte_count)
      3'd0:    byte_mask = 32'h0000_0000;
      3'd1:    byte_mask = 32'h0000_00ff;
      3'd2:    byte_mask = 32'h0000_ffff;
      3'd3:    byte_mask = 32'h00ff_ffff;
      default: byte_mask = 32'hffff_ffff;
    endcase
  end

  // A transfer goes straight into the queue whenever it has room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.data      = data_word & byte_mask;
    q_item.has_bytes = (byte_count != 3'd0);
    q_item.first     = first_word;
    q_item.last      = last_word;
    q_item.seed      = SEED_BASE + total_length;
  end

endmodule

`default_nettype wire

// ----- design/lk3_queue.sv -----
// Small first-in first-out queue of classified words between front and back.
`default_nettype none

module lk3_queue #(
  parameter int DEPTH = lk3_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lk3_pkg::item_t push_item,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output lk3_pkg::item_t     head_item
);
  import lk3_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  item_t         store [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head_item = store[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_item;
    end
  end

  // Pointers wrap at the configured depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/lk3_back.sv -----
// Back part: accumulates words, runs the block and final mixes, holds the result.
`default_nettype none

module lk3_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire lk3_pkg::item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [31:0]         hash_value
);
  import lk3_pkg::*;

  // Sequencer states.
  localparam logic [1:0] S_RUN = 2'd0;  // take words from the queue
  localparam logic [1:0] S_MIX = 2'd1;  // block mix in progress
  localparam logic [1:0] S_ADD = 2'd2;  // add the held word after a mix
  localparam logic [1:0] S_FIN = 2'd3;  // final mix in progress

  // Slot code for a full block that has not been mixed yet.
  localparam logic [1:0] SLOT_FULL = 2'd3;
  localparam logic [1:0] STEP_LAST = 2'd3;
  localparam logic [1:0] MIX_LAST  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [1:0] step;
  logic [1:0] step_next;
  abc_t       acc;
  abc_t       acc_next;
  logic [1:0] slot;
  logic [1:0] slot_next;
  item_t      held;
  logic       hold_load;
  logic       out_load;
  logic [31:0] out_data;

  item_t      cur;
  abc_t       base;
  abc_t       added;
  logic [1:0] slot0;
  logic [1:0] slot1;
  logic       emit_now;
  logic       go_fin;
  logic       out_free;
  logic       proc_ok;
  logic       need_mix;
  abc_t       mix_out;
  abc_t       fin_out;

  assign out_free = !out_valid || !out_stall;

  // Word processing: optional seed, then add into the current slot.
  always_comb begin
    cur   = (state == S_ADD) ? held : q_item;
    base  = acc;
    slot0 = slot;
    if (cur.first) begin
      base.a = cur.seed;
      base.b = cur.seed;
      base.c = cur.seed;
      slot0  = 2'd0;
    end
    added = base;
    slot1 = slot0;
    if (cur.has_bytes && slot0 != SLOT_FULL) begin
      case (slot0)
        2'd0:    added.a = base.a + cur.data;
        2'd1:    added.b = base.b + cur.data;
        default: added.c = base.c + cur.data;
      endcase
      slot1 = slot0 + 2'd1;
    end
    emit_now = cur.last && (slot1 == 2'd0);
    go_fin   = cur.last && (slot1 != 2'd0);
    proc_ok  = !emit_now || out_free;
    need_mix = cur.has_bytes && !cur.first && (slot == SLOT_FULL);
  end

  assign mix_out = block_pair(acc, (state == S_RUN) ? 2'd0 : step);
  assign fin_out = final_pair(acc, step);

  // Sequencer.
  always_comb begin
    state_next = state;
    step_next  = step;
    acc_next   = acc;
    slot_next  = slot;
    hold_load  = 1'b0;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    out_data   = acc.c;
    case (state)
      S_RUN: begin
        if (q_valid && need_mix) begin
          q_pop      = 1'b1;
          hold_load  = 1'b1;
          acc_next   = mix_out;
          slot_next  = 2'd0;
          step_next  = 2'd1;
          state_next = S_MIX;
        end else if (q_valid && proc_ok) begin
          q_pop     = 1'b1;
          acc_next  = added;
          slot_next = cur.last ? 2'd0 : slot1;
          step_next = 2'd0;
          out_load  = emit_now;
          out_data  = added.c;
          if (go_fin) begin
            state_next = S_FIN;
          end
        end
      end
      S_MIX: begin
        acc_next  = mix_out;
        step_next = step + 2'd1;
        if (step == MIX_LAST) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (proc_ok) begin
          acc_next   = added;
          slot_next  = cur.last ? 2'd0 : slot1;
          step_next  = 2'd0;
          out_load   = emit_now;
          out_data   = added.c;
          state_next = go_fin ? S_FIN : S_RUN;
        end
      end
      S_FIN: begin
        if (step != STEP_LAST) begin
          acc_next  = fin_out;
          step_next = step + 2'd1;
        end else if (out_free) begin
          acc_next   = fin_out;
          out_load   = 1'b1;
          out_data   = fin_out.c;
          step_next  = 2'd0;
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  // Control and accumulator registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      step      <= 2'd0;
      acc       <= '0;
      slot      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      acc   <= acc_next;
      slot  <= slot_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: the word held across a block mix and the result.
  always_ff @(posedge clk) begin
    if (hold_load) begin
      held <= q_item;
    end
    if (out_load) begin
      hash_value <= out_data;
    end
  end

endmodule

`default_nettype wire

// ----- design/lk3_checker.sv -----
// Port-level checks on the byte hash unit and the bind that attaches them.
`default_nettype none

module lk3_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        last_word,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] hash_value
);

  // Messages closed at the input whose hash has not yet been transferred out.
  logic [7:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {7'd0, in_valid && !in_stall && last_word}
                         - {7'd0, out_valid && !out_stall};
    end
  end

  // A result is shown only for a message whose last word was taken.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 8'd0)
    else $error("result shown with no message outstanding");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hash_value))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Reset leaves the input open.
  a_reset_input: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind lookup3_byte_hash_unit lk3_checker u_lk3_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .last_word  (last_word),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hash_value (hash_value)
);

`default_nettype wire
